>>> hdl/read_coverage_pileup_macros.svh
// Assertion macros shared by the coverage pileup RTL.
`ifndef READ_COVERAGE_PILEUP_MACROS_SVH
`define READ_COVERAGE_PILEUP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RCP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define RCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/rcp_pkg.sv
// Types and constants shared by the coverage pileup controller and datapath.
`timescale 1ns / 1ps
package rcp_pkg;

   localparam int POS_W   = 34;
   localparam int CNT_W   = 32;
   localparam int OP_W    = 4;

   localparam logic [1:0] MODE_ADD   = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [1:0] CSR_REGION_START = 2'd0;
   localparam logic [1:0] CSR_REGION_END   = 2'd1;

   localparam logic [30:0] REGION_START_RESET = 31'd1;
   localparam logic [30:0] REGION_END_RESET   = 31'd1024;

   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   // datapath operations issued by the controller
   localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
   localparam logic [OP_W-1:0] OP_LATCH     = 4'd1;
   localparam logic [OP_W-1:0] OP_SPAN_DIFF = 4'd2;
   localparam logic [OP_W-1:0] OP_SPAN_CLIP = 4'd3;
   localparam logic [OP_W-1:0] OP_SPAN_LIM  = 4'd4;
   localparam logic [OP_W-1:0] OP_BOUND_LO  = 4'd5;
   localparam logic [OP_W-1:0] OP_BOUND_HI  = 4'd6;
   localparam logic [OP_W-1:0] OP_OFFSETS   = 4'd7;
   localparam logic [OP_W-1:0] OP_RD        = 4'd8;
   localparam logic [OP_W-1:0] OP_WR        = 4'd9;
   localparam logic [OP_W-1:0] OP_B2A       = 4'd10;
   localparam logic [OP_W-1:0] OP_B2B       = 4'd11;
   localparam logic [OP_W-1:0] OP_CLR       = 4'd12;
   localparam logic [OP_W-1:0] OP_READ_REQ  = 4'd13;
   localparam logic [OP_W-1:0] OP_READ_OUT  = 4'd14;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       has_second;
      logic       run;
      logic       walk_last;
      logic       clr_last;
   } dp_sts_type;

endpackage

>>> hdl/read_coverage_pileup.sv
// Top level of the per-base read coverage pileup block.
`timescale 1ns / 1ps
// Usage:
//  Pulse start with the req_ word while busy is low; the word is taken at
//  that edge. req_mode selects add alignment, read counter or clear store.
//  Add: setup runs first, then each covered base costs one counter
//  memory read and one write back; a second block runs its own setup
//  and then its own walk over its bases.
//  Read: after setup and a counter read, rsp_valid strobes for one cycle
//  with rsp_depth_count and rsp_in_region; busy drops in that same cycle.
//  Clear: after setup, one counter zeroed per cycle across the store.
//  Mode 3: setup only, no effect.
//  The counter memory has one write port and one registered read port.
//  Reset: synchronous, active high. After release a clearing pass over
//  the whole store zeroes it with busy high; csr_ writes are
//  still taken. Registers: index 0 region_start, index 1 region_end,
//  written whenever csr_valid is high (csr_ready is always high); write
//  them only while the block is idle.
//  Results cannot be held off: each word shows for exactly one cycle.
module read_coverage_pileup
   import rcp_pkg::*;
#(
   parameter int REGION_DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_mode,
   input  logic [30:0]      req_align_pos,
   input  logic [27:0]      req_first_len,
   input  logic [27:0]      req_gap_len,
   input  logic [27:0]      req_second_len,
   input  logic             req_has_second,
   input  logic [9:0]       req_read_index,
   output logic             rsp_valid,
   output logic [CNT_W-1:0] rsp_depth_count,
   output logic             rsp_in_region,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   assign csr_ready = 1'b1;

   rcp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   rcp_dp #(
      .REGION_DEPTH (REGION_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_mode        (req_mode),
      .req_align_pos   (req_align_pos),
      .req_first_len   (req_first_len),
      .req_gap_len     (req_gap_len),
      .req_second_len  (req_second_len),
      .req_has_second  (req_has_second),
      .req_read_index  (req_read_index),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_depth_count (rsp_depth_count),
      .rsp_in_region   (rsp_in_region)
   );

endmodule

>>> hdl/rcp_ctrl.sv
// Sequencer for setup, per-base walk, clearing pass and counter reads.
`timescale 1ns / 1ps
`include "read_coverage_pileup_macros.svh"
module rcp_ctrl
   import rcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_CLEAR     = 4'd1;
   localparam logic [3:0] ST_SPAN_DIFF = 4'd2;
   localparam logic [3:0] ST_SPAN_CLIP = 4'd3;
   localparam logic [3:0] ST_SPAN_LIM  = 4'd4;
   localparam logic [3:0] ST_BOUND_LO  = 4'd5;
   localparam logic [3:0] ST_BOUND_HI  = 4'd6;
   localparam logic [3:0] ST_OFFSETS   = 4'd7;
   localparam logic [3:0] ST_WALK_RD   = 4'd8;
   localparam logic [3:0] ST_WALK_WR   = 4'd9;
   localparam logic [3:0] ST_B2A       = 4'd10;
   localparam logic [3:0] ST_B2B       = 4'd11;
   localparam logic [3:0] ST_READ_REQ  = 4'd12;
   localparam logic [3:0] ST_READ_OUT  = 4'd13;

   logic [3:0] state_ff, state_in;
   logic       blk2_ff, blk2_in;
   logic [3:0] block_done_state;

   // after a block: move on to the second one or finish
   assign block_done_state = (!blk2_ff && sts.has_second) ? ST_B2A : ST_IDLE;

   always_comb begin
      state_in = state_ff;
      blk2_in  = blk2_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.op   = OP_LATCH;
               blk2_in  = 1'b0;
               state_in = ST_SPAN_DIFF;
            end
         end
         ST_CLEAR: begin
            cmd.op = OP_CLR;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_SPAN_DIFF: begin
            cmd.op   = OP_SPAN_DIFF;
            state_in = ST_SPAN_CLIP;
         end
         ST_SPAN_CLIP: begin
            cmd.op   = OP_SPAN_CLIP;
            state_in = ST_SPAN_LIM;
         end
         ST_SPAN_LIM: begin
            cmd.op = OP_SPAN_LIM;
            case (sts.mode)
               MODE_ADD:   state_in = ST_BOUND_LO;
               MODE_READ:  state_in = ST_READ_REQ;
               MODE_CLEAR: state_in = ST_CLEAR;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_BOUND_LO: begin
            cmd.op   = OP_BOUND_LO;
            state_in = ST_BOUND_HI;
         end
         ST_BOUND_HI: begin
            cmd.op   = OP_BOUND_HI;
            state_in = ST_OFFSETS;
         end
         ST_OFFSETS: begin
            cmd.op   = OP_OFFSETS;
            state_in = sts.run ? ST_WALK_RD : block_done_state;
         end
         ST_WALK_RD: begin
            cmd.op   = OP_RD;
            state_in = ST_WALK_WR;
         end
         ST_WALK_WR: begin
            cmd.op   = OP_WR;
            state_in = sts.walk_last ? block_done_state : ST_WALK_RD;
         end
         ST_B2A: begin
            cmd.op   = OP_B2A;
            blk2_in  = 1'b1;
            state_in = ST_B2B;
         end
         ST_B2B: begin
            cmd.op   = OP_B2B;
            state_in = ST_BOUND_LO;
         end
         ST_READ_REQ: begin
            cmd.op   = OP_READ_REQ;
            state_in = ST_READ_OUT;
         end
         ST_READ_OUT: begin
            cmd.op   = OP_READ_OUT;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         blk2_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         blk2_ff  <= blk2_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   `RCP_ASSERT_NEXT(a_walk_pair, clock, reset, state_ff == ST_WALK_RD,
      state_ff == ST_WALK_WR, "walk read not followed by its write")
   `RCP_ASSERT_NEXT(a_clear_hold, clock, reset, (state_ff == ST_CLEAR) && !sts.clr_last,
      state_ff == ST_CLEAR, "clearing pass left early")

endmodule

>>> hdl/rcp_dp.sv
// Region bounds, coverage counter memory and result register.
`timescale 1ns / 1ps
`include "read_coverage_pileup_macros.svh"
module rcp_dp
   import rcp_pkg::*;
#(
   parameter int REGION_DEPTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_sts_type        sts,
   input  logic [1:0]        req_mode,
   input  logic [30:0]       req_align_pos,
   input  logic [27:0]       req_first_len,
   input  logic [27:0]       req_gap_len,
   input  logic [27:0]       req_second_len,
   input  logic              req_has_second,
   input  logic [9:0]        req_read_index,
   input  logic              csr_valid,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   output logic              rsp_valid,
   output logic [CNT_W-1:0]  rsp_depth_count,
   output logic              rsp_in_region
);

   localparam int AW     = (REGION_DEPTH > 1) ? $clog2(REGION_DEPTH) : 1;
   localparam int SPAN_W = $clog2(REGION_DEPTH + 1);
   localparam logic [31:0]   DEPTH32 = 32'(REGION_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(REGION_DEPTH - 1);

   logic [30:0] region_start_ff, region_end_ff;

   logic [1:0]        mode_ff, mode_in;
   logic              has_second_ff, has_second_in;
   logic [9:0]        read_index_ff, read_index_in;
   logic [27:0]       len_ff, len_in, len1_ff, len1_in, gap_ff, gap_in, len2_ff, len2_in;
   logic [POS_W-1:0]  first_ff, first_in, lo_ff, lo_in, hi_ff, hi_in, lim_ff, lim_in;
   logic [31:0]       diff_ff, diff_in;
   logic              empty_ff, empty_in;
   logic [SPAN_W-1:0] span_ff, span_in;
   logic              ok_ff, ok_in;
   logic [AW-1:0]     cur_ff, cur_in, end_ff, end_in, clr_ff, clr_in;
   logic              hit_ff, hit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  depth_count_ff, depth_count_in;
   logic              in_region_ff, in_region_in;

   logic [CNT_W-1:0]  mem [REGION_DEPTH];
   logic [CNT_W-1:0]  rdata_ff;
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [CNT_W-1:0]  mem_wdata;

   logic [POS_W-1:0]  rs34, lo_off, hi_off;

   assign rs34   = {3'b000, region_start_ff};
   assign lo_off = lo_ff - rs34;
   assign hi_off = hi_ff - rs34;

   always_comb begin
      mode_in        = mode_ff;
      has_second_in  = has_second_ff;
      read_index_in  = read_index_ff;
      len_in         = len_ff;
      len1_in        = len1_ff;
      gap_in         = gap_ff;
      len2_in        = len2_ff;
      first_in       = first_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      lim_in         = lim_ff;
      diff_in        = diff_ff;
      empty_in       = empty_ff;
      span_in        = span_ff;
      ok_in          = ok_ff;
      cur_in         = cur_ff;
      end_in         = end_ff;
      clr_in         = clr_ff;
      hit_in         = hit_ff;
      rsp_valid_in   = 1'b0;
      depth_count_in = depth_count_ff;
      in_region_in   = in_region_ff;
      case (cmd.op)
         OP_LATCH: begin
            mode_in       = req_mode;
            has_second_in = req_has_second;
            read_index_in = req_read_index;
            first_in      = {3'b000, req_align_pos} + 34'd1;
            len_in        = req_first_len;
            len1_in       = req_first_len;
            gap_in        = req_gap_len;
            len2_in       = req_second_len;
         end
         OP_SPAN_DIFF: begin
            diff_in  = {1'b0, region_end_ff} - {1'b0, region_start_ff} + 32'd1;
            empty_in = (region_end_ff < region_start_ff);
         end
         OP_SPAN_CLIP: begin
            if (empty_ff) span_in = '0;
            else if (diff_ff > DEPTH32) span_in = SPAN_W'(REGION_DEPTH);
            else span_in = diff_ff[SPAN_W-1:0];
         end
         OP_SPAN_LIM: lim_in = rs34 + POS_W'(span_ff) - 34'd1;
         OP_B2A:      first_in = first_ff + POS_W'(len1_ff);
         OP_B2B: begin
            first_in = first_ff + POS_W'(gap_ff);
            len_in   = len2_ff;
         end
         OP_BOUND_LO: begin
            lo_in = (first_ff < rs34) ? rs34 : first_ff;
            hi_in = first_ff + POS_W'(len_ff) - 34'd1;
         end
         OP_BOUND_HI: begin
            hi_in = (hi_ff > lim_ff) ? lim_ff : hi_ff;
            ok_in = (len_ff != '0) && (span_ff != '0);
         end
         OP_OFFSETS: begin
            cur_in = lo_off[AW-1:0];
            end_in = hi_off[AW-1:0];
         end
         OP_WR:  cur_in = cur_ff + AW'(1);
         OP_CLR: clr_in = (clr_ff == LAST_ADDR) ? '0 : clr_ff + AW'(1);
         OP_READ_REQ: hit_in = (POS_W'(read_index_ff) < POS_W'(span_ff));
         OP_READ_OUT: begin
            rsp_valid_in   = 1'b1;
            depth_count_in = hit_ff ? rdata_ff : '0;
            in_region_in   = hit_ff;
         end
         default: ;
      endcase
   end

   // memory port control: one write and one registered read per cycle
   assign mem_we    = (cmd.op == OP_WR) || (cmd.op == OP_CLR);
   assign mem_waddr = (cmd.op == OP_CLR) ? clr_ff : cur_ff;
   assign mem_wdata = (cmd.op == OP_CLR) ? '0 :
                      ((rdata_ff == COUNT_MAX) ? rdata_ff : rdata_ff + 32'd1);
   assign mem_re    = (cmd.op == OP_RD) || (cmd.op == OP_READ_REQ);
   assign mem_raddr = (cmd.op == OP_RD) ? cur_ff : AW'(read_index_ff);

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_start_ff <= REGION_START_RESET;
         region_end_ff   <= REGION_END_RESET;
         clr_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid && (csr_index == CSR_REGION_START)) region_start_ff <= csr_wdata[30:0];
         if (csr_valid && (csr_index == CSR_REGION_END))   region_end_ff   <= csr_wdata[30:0];
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      has_second_ff  <= has_second_in;
      read_index_ff  <= read_index_in;
      len_ff         <= len_in;
      len1_ff        <= len1_in;
      gap_ff         <= gap_in;
      len2_ff        <= len2_in;
      first_ff       <= first_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      lim_ff         <= lim_in;
      diff_ff        <= diff_in;
      empty_ff       <= empty_in;
      span_ff        <= span_in;
      ok_ff          <= ok_in;
      cur_ff         <= cur_in;
      end_ff         <= end_in;
      hit_ff         <= hit_in;
      depth_count_ff <= depth_count_in;
      in_region_ff   <= in_region_in;
   end

   assign sts.mode       = mode_ff;
   assign sts.has_second = has_second_ff;
   assign sts.run        = ok_ff && (lo_ff <= hi_ff);
   assign sts.walk_last  = (cur_ff == end_ff);
   assign sts.clr_last   = (clr_ff == LAST_ADDR);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_depth_count = depth_count_ff;
   assign rsp_in_region   = in_region_ff;

   `RCP_ASSERT_NEXT(a_rsp_after_read, clock, reset, cmd.op == OP_READ_OUT,
      rsp_valid_ff && (in_region_ff == $past(hit_ff)), "read result word missing")
   `RCP_ASSERT_NOW(a_walk_in_range, clock, reset, cmd.op == OP_WR,
      cur_ff <= end_ff, "walk ran past block end")
   `RCP_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid_ff && !in_region_ff,
      depth_count_ff == '0, "out-of-region read returned nonzero count")

endmodule

>>> tb/read_coverage_pileup_tb.sv
// Self-checking testbench for the read coverage pileup block.
`timescale 1ns / 1ps
module read_coverage_pileup_tb
   import rcp_pkg::*;
();

   localparam int          STORE_DEPTH = 1024;
   localparam logic [1:0]  MODE_UNUSED = 2'd3;
   localparam logic [1:0]  CSR_UNUSED  = 2'd3;
   localparam int          SETTLE      = 16;
   localparam int          PHASE_WORDS = 194;
   // hang guard: clearing pass plus every word at the longest clipped add
   // and the longest pause, taken a few times over
   localparam int unsigned CYCLE_LIMIT = 40_000_000;

   typedef struct {
      logic [1:0]  mode;
      logic [30:0] align_pos;
      logic [27:0] first_len;
      logic [27:0] gap_len;
      logic [27:0] second_len;
      logic        has_second;
      logic [9:0]  read_index;
   } pileup_req_type;

   // Mirror of the counter store plus the queue of reads still to come back.
   class coverage_scoreboard;
      logic [31:0] counts [STORE_DEPTH];
      logic [30:0] region_start;
      logic [30:0] region_end;
      logic [31:0] want_count [$];
      logic        want_region [$];
      int          errors;

      function new();
         region_start = REGION_START_RESET;
         region_end   = REGION_END_RESET;
         foreach (counts[i]) counts[i] = '0;
         errors = 0;
      endfunction

      function int span();
         longint unsigned s, e, n;
         s = region_start;
         e = region_end;
         if (e < s) return 0;
         n = e - s + 1;
         if (n > STORE_DEPTH) n = STORE_DEPTH;
         return int'(n);
      endfunction

      function void count_block(longint unsigned first, longint unsigned len);
         longint unsigned lo, hi, rs, n;
         if (len == 0) return;
         n = span();
         if (n == 0) return;
         rs = region_start;
         lo = first;
         hi = first + len - 1;
         if (lo < rs) lo = rs;
         if (hi > rs + n - 1) hi = rs + n - 1;
         for (longint unsigned p = lo; p <= hi; p++) begin
            if (counts[p - rs] != COUNT_MAX) counts[p - rs] = counts[p - rs] + 1;
         end
      endfunction

      function void set_register(logic [1:0] idx, logic [31:0] data);
         if (idx == CSR_REGION_START) region_start = data[30:0];
         else if (idx == CSR_REGION_END) region_end = data[30:0];
      endfunction

      function void note_request(pileup_req_type w);
         longint unsigned s1;
         case (w.mode)
            MODE_ADD: begin
               s1 = longint'(w.align_pos) + 1;
               count_block(s1, w.first_len);
               if (w.has_second) count_block(s1 + w.first_len + w.gap_len, w.second_len);
            end
            MODE_READ: begin
               if (int'(w.read_index) < span()) begin
                  want_count  = {want_count, counts[w.read_index]};
                  want_region = {want_region, 1'b1};
               end else begin
                  want_count  = {want_count, 32'd0};
                  want_region = {want_region, 1'b0};
               end
            end
            MODE_CLEAR: begin
               foreach (counts[i]) counts[i] = '0;
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [31:0] cnt, logic inreg);
         logic [31:0] ec;
         logic        er;
         if (want_count.size() == 0) begin
            $error("result with no read outstanding: depth_count %0d in_region %0b",
                   cnt, inreg);
            errors++;
            return;
         end
         ec = want_count.pop_front();
         er = want_region.pop_front();
         if (cnt !== ec) begin
            $error("depth_count: expected %0d, actual %0d", ec, cnt);
            errors++;
         end
         if (inreg !== er) begin
            $error("in_region: expected %0b, actual %0b", er, inreg);
            errors++;
         end
      endfunction

      function int pending();
         return want_count.size();
      endfunction
   endclass

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        start          = 1'b0;
   logic        busy;
   logic [1:0]  req_mode       = '0;
   logic [30:0] req_align_pos  = '0;
   logic [27:0] req_first_len  = '0;
   logic [27:0] req_gap_len    = '0;
   logic [27:0] req_second_len = '0;
   logic        req_has_second = 1'b0;
   logic [9:0]  req_read_index = '0;
   logic        rsp_valid;
   logic [31:0] rsp_depth_count;
   logic        rsp_in_region;
   logic        csr_valid      = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index      = '0;
   logic [31:0] csr_wdata      = '0;

   coverage_scoreboard sb;
   int unsigned        cycle_count = 0;

   read_coverage_pileup #(.REGION_DEPTH(STORE_DEPTH)) uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_align_pos  (req_align_pos),
      .req_first_len  (req_first_len),
      .req_gap_len    (req_gap_len),
      .req_second_len (req_second_len),
      .req_has_second (req_has_second),
      .req_read_index (req_read_index),
      .rsp_valid      (rsp_valid),
      .rsp_depth_count(rsp_depth_count),
      .rsp_in_region  (rsp_in_region),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[read_coverage_pileup] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_depth_count, rsp_in_region);
   end

   function automatic pileup_req_type make_word(logic [1:0] mode, logic [30:0] pos,
                                                logic [27:0] l1, logic [27:0] gap,
                                                logic [27:0] l2, logic hs, logic [9:0] idx);
      pileup_req_type w;
      w.mode       = mode;
      w.align_pos  = pos;
      w.first_len  = l1;
      w.gap_len    = gap;
      w.second_len = l2;
      w.has_second = hs;
      w.read_index = idx;
      return w;
   endfunction

   // mostly short reads, some medium, a few huge that get clipped
   function automatic logic [27:0] pick_len();
      int t;
      t = $urandom_range(0, 99);
      if (t < 80) return 28'($urandom_range(0, 24));
      if (t < 95) return 28'($urandom_range(0, 400));
      return 28'($urandom);
   endfunction

   function automatic pileup_req_type random_word();
      pileup_req_type w;
      int             r;
      int             n;
      longint         pos;
      w.align_pos  = 31'($urandom);
      if (&w.align_pos) w.align_pos = w.align_pos - 1;
      w.first_len  = 28'($urandom);
      w.gap_len    = 28'($urandom);
      w.second_len = 28'($urandom);
      w.has_second = 1'($urandom_range(0, 1));
      w.read_index = 10'($urandom);
      n = sb.span();
      r = $urandom_range(0, 99);
      if (r < 55) begin
         w.mode = MODE_ADD;
         // land most alignments on or around the counted region
         if ($urandom_range(0, 99) >= 8) begin
            pos = longint'(sb.region_start) - 1 + longint'($urandom_range(0, n + 100)) - 50;
            if (pos < 0) pos = 0;
            if (pos > 64'd2147483646) pos = 64'd2147483646;
            w.align_pos = pos[30:0];
         end
         w.first_len  = pick_len();
         w.second_len = pick_len();
         r = $urandom_range(0, 99);
         if (r < 70) w.gap_len = 28'($urandom_range(0, 30));
         else if (r < 95) w.gap_len = 28'($urandom_range(0, 500));
      end else if (r < 91) begin
         w.mode = MODE_READ;
         if ($urandom_range(0, 99) < 70) begin
            w.read_index = 10'($urandom_range(0, (n + 8 > 1023) ? 1023 : n + 8));
         end
      end else if (r < 95) begin
         w.mode = MODE_CLEAR;
      end else begin
         w.mode = MODE_UNUSED;
      end
      return w;
   endfunction

   // raise start with the word and hold it until the block takes it
   task automatic send_word(input pileup_req_type w);
      start          <= 1'b1;
      req_mode       <= w.mode;
      req_align_pos  <= w.align_pos;
      req_first_len  <= w.first_len;
      req_gap_len    <= w.gap_len;
      req_second_len <= w.second_len;
      req_has_second <= w.has_second;
      req_read_index <= w.read_index;
      do @(posedge clock); while (busy);
      sb.note_request(w);
   endtask

   task automatic pause_sender(input int n);
      start         <= 1'b0;
      req_align_pos <= 31'($urandom);
      req_first_len <= 28'($urandom);
      repeat (n) @(posedge clock);
   endtask

   // hold off until every read is back and the block has gone idle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0 || busy) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic program_region(input longint s, input longint e, input bit poke_unused);
      logic [1:0]  idx [3];
      logic [31:0] val [3];
      int          cnt;
      idx[0] = CSR_REGION_START;
      idx[1] = CSR_REGION_END;
      idx[2] = CSR_UNUSED;
      val[0] = {1'($urandom_range(0, 1)), s[30:0]};
      val[1] = {1'($urandom_range(0, 1)), e[30:0]};
      val[2] = $urandom;
      cnt = poke_unused ? 3 : 2;
      csr_valid <= 1'b1;
      for (int k = 0; k < cnt; k++) begin
         csr_index <= idx[k];
         csr_wdata <= val[k];
         do @(posedge clock); while (!csr_ready);
         sb.set_register(idx[k], val[k]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic run_directed();
      // default region 1..1024: edges, clipping, zero lengths, second block
      send_word(make_word(MODE_ADD, 31'd0, 28'd1, 28'd0, 28'd0, 1'b0, 10'd0));
      send_word(make_word(MODE_ADD, 31'd1023, 28'd1, 28'd0, 28'd0, 1'b0, 10'd0));
      send_word(make_word(MODE_ADD, 31'd1020, 28'd10, 28'd0, 28'd0, 1'b0, 10'd0));
      send_word(make_word(MODE_ADD, 31'd0, 28'd0, 28'd0, 28'd0, 1'b1, 10'd0));
      send_word(make_word(MODE_ADD, 31'd5, 28'd3, 28'd4, 28'd6, 1'b1, 10'd0));
      send_word(make_word(MODE_ADD, 31'd5, 28'd3, 28'd4, 28'd6, 1'b0, 10'd0));
      send_word(make_word(MODE_ADD, 31'd2147483646, '1, '1, '1, 1'b1, 10'd0));
      send_word(make_word(MODE_ADD, 31'd0, '1, 28'd0, 28'd0, 1'b0, 10'd0));
      send_word(make_word(MODE_UNUSED, '1, '1, '1, '1, 1'b1, '1));
      send_word(make_word(MODE_READ, 31'd0, 28'd0, 28'd0, 28'd0, 1'b0, 10'd0));
      send_word(make_word(MODE_READ, 31'd0, 28'd0, 28'd0, 28'd0, 1'b0, 10'd5));
      send_word(make_word(MODE_READ, 31'd0, 28'd0, 28'd0, 28'd0, 1'b0, 10'd12));
      send_word(make_word(MODE_READ, 31'd0, 28'd0, 28'd0, 28'd0, 1'b0, 10'd15));
      send_word(make_word(MODE_READ, 31'd0, 28'd0, 28'd0, 28'd0, 1'b0, 10'd1023));
      send_word(make_word(MODE_CLEAR, 31'd0, 28'd0, 28'd0, 28'd0, 1'b0, 10'd0));
      send_word(make_word(MODE_READ, 31'd0, 28'd0, 28'd0, 28'd0, 1'b0, 10'd0));
      send_word(make_word(MODE_READ, 31'd0, 28'd0, 28'd0, 28'd0, 1'b0, 10'd1023));
      drain();
      // empty region: adds do nothing, reads fall outside
      program_region(100, 99, 1'b0);
      send_word(make_word(MODE_ADD, 31'd98, 28'd5, 28'd0, 28'd0, 1'b0, 10'd0));
      send_word(make_word(MODE_READ, 31'd0, 28'd0, 28'd0, 28'd0, 1'b0, 10'd0));
      drain();
      // region from position zero: offset 0 is never covered
      program_region(0, 1023, 1'b0);
      send_word(make_word(MODE_ADD, 31'd0, 28'd5, 28'd0, 28'd0, 1'b0, 10'd0));
      send_word(make_word(MODE_READ, 31'd0, 28'd0, 28'd0, 28'd0, 1'b0, 10'd0));
      send_word(make_word(MODE_READ, 31'd0, 28'd0, 28'd0, 28'd0, 1'b0, 10'd1));
      drain();
      // single position at the top of the coordinate range
      program_region(64'h7FFFFFFF, 64'h7FFFFFFF, 1'b0);
      send_word(make_word(MODE_ADD, 31'd2147483646, 28'd1, 28'd0, 28'd2, 1'b1, 10'd0));
      send_word(make_word(MODE_READ, 31'd0, 28'd0, 28'd0, 28'd0, 1'b0, 10'd0));
      send_word(make_word(MODE_READ, 31'd0, 28'd0, 28'd0, 28'd0, 1'b0, 10'd1));
      drain();
   endtask

   task automatic run_phase(input int idle_pct, input int words);
      pileup_req_type w;
      int             sent;
      sent = 0;
      while (sent < words) begin
         w = random_word();
         send_word(w);
         sent++;
         if ($urandom_range(0, 99) < 2) begin
            drain();
         end else if ($urandom_range(0, 99) < idle_pct) begin
            pause_sender($urandom_range(0, 9) == 0 ? $urandom_range(10, 60)
                                                   : $urandom_range(1, 6));
         end
      end
      drain();
   endtask

   initial begin
      longint rs;
      longint re;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      program_region(1, 1024, 1'b0);
      run_phase(0, PHASE_WORDS);
      program_region(0, 300, 1'b0);
      run_phase(67, PHASE_WORDS);
      program_region(64'h7FFFFFFF - 600, 64'h7FFFFFFF, 1'b0);
      run_phase(8, PHASE_WORDS);
      program_region(777, 777 + 5000, 1'b1);
      run_phase(0, PHASE_WORDS);
      program_region(50, 40, 1'b0);
      run_phase(67, PHASE_WORDS);
      rs = $urandom_range(1, 32'h7FFFFFFF);
      re = rs + $urandom_range(0, 1500);
      if (re > 64'h7FFFFFFF) re = 64'h7FFFFFFF;
      program_region(rs, re, 1'b0);
      run_phase(67, PHASE_WORDS);
      program_region(1, 1, 1'b0);
      run_phase(8, PHASE_WORDS);
      program_region(3000, 3000 + 1023, 1'b0);
      run_phase(0, PHASE_WORDS);
      drain();
      if (sb.errors == 0) begin
         $display("[read_coverage_pileup] OK");
      end else begin
         $display("[read_coverage_pileup] ERROR");
      end
      $finish;
   end

endmodule
